// ----- rtl/uad_pkg.sv -----
// ----------------------------------------------------------------------------
// uad_pkg
// Shared types, sizes and helpers for the unsigned-to-ASCII digit converter.
// ----------------------------------------------------------------------------
package uad_pkg;

  localparam int FIELD_WIDTH = 32;
  localparam int VALUE_WIDTH = 32;
  localparam int CONV_WIDTH  = (VALUE_WIDTH < FIELD_WIDTH) ? VALUE_WIDTH : FIELD_WIDTH;
  // decimal digits needed for CONV_WIDTH bits: ceil(width * log10(2))
  localparam int LANES       = (CONV_WIDTH * 30103 + 99999) / 100000;
  localparam int LANE_BITS   = LANES * 4;
  localparam int PAD_W       = LANE_BITS - CONV_WIDTH;
  localparam int REM_W       = $clog2(LANES + 1);
  localparam int BIT_CNT_W   = $clog2(CONV_WIDTH + 1);
  localparam int CNT_W       = 4;

  localparam logic [6:0] CHAR_ZERO    = 7'd48;
  localparam logic [6:0] CHAR_UPPER_A = 7'd65;
  localparam logic [6:0] CHAR_LOWER_A = 7'd97;

  typedef enum logic [1:0] {
    REQ_DEC       = 2'd0,
    REQ_HEX_LOWER = 2'd1,
    REQ_HEX_UPPER = 2'd2
  } req_type_t;

  typedef struct packed {
    logic [1:0]             req_type;
    logic [FIELD_WIDTH-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [6:0]       ascii_char;
    logic             last_char;
    logic [CNT_W-1:0] char_count;
  } out_item_t;

  typedef logic [LANES-1:0][3:0] lanes_t;

  typedef struct packed {
    logic   valid;
    logic   upper;
    lanes_t lanes;
  } conv_result_t;

  function automatic logic [6:0] digit_char(input logic [3:0] nib, input logic upper);
    logic [6:0] c;
    if (nib < 4'd10) begin
      c = CHAR_ZERO + {3'b000, nib};
    end else if (upper) begin
      c = CHAR_UPPER_A + {3'b000, nib - 4'd10};
    end else begin
      c = CHAR_LOWER_A + {3'b000, nib - 4'd10};
    end
    return c;
  endfunction

endpackage

// ----- rtl/uad_conv.sv -----
// ----------------------------------------------------------------------------
// uad_conv
// Digit loader: hex values load straight into nibble lanes, decimal values
// run a bit-serial shift-add-3 conversion, one input bit per cycle.
// ----------------------------------------------------------------------------
module uad_conv (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  uad_pkg::in_item_t    item,
  output logic                 busy,
  output uad_pkg::conv_result_t result
);

  typedef enum logic [1:0] {
    C_IDLE  = 2'b01,
    C_SHIFT = 2'b10
  } conv_state_t;

  conv_state_t                        state_r, state_nxt;
  logic                               done_r, done_nxt;
  logic                               upper_r, upper_nxt;
  uad_pkg::lanes_t                    lanes_r, lanes_nxt;
  logic [uad_pkg::CONV_WIDTH-1:0]     bits_r, bits_nxt;
  logic [uad_pkg::BIT_CNT_W-1:0]      cnt_r, cnt_nxt;
  uad_pkg::lanes_t                    adj;
  logic [uad_pkg::LANE_BITS-1:0]      adj_bits;

  always_comb begin
    for (int i = 0; i < uad_pkg::LANES; i++) begin
      adj[i] = (lanes_r[i] >= 4'd5) ? lanes_r[i] + 4'd3 : lanes_r[i];
    end
  end

  assign adj_bits = adj;

  always_comb begin
    state_nxt = state_r;
    done_nxt  = 1'b0;
    upper_nxt = upper_r;
    lanes_nxt = lanes_r;
    bits_nxt  = bits_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      C_IDLE: begin
        if (start) begin
          upper_nxt = (item.req_type != uad_pkg::REQ_HEX_LOWER);
          if (item.req_type == uad_pkg::REQ_DEC) begin
            lanes_nxt = '0;
            bits_nxt  = item.value[uad_pkg::CONV_WIDTH-1:0];
            cnt_nxt   = uad_pkg::BIT_CNT_W'(uad_pkg::CONV_WIDTH);
            state_nxt = C_SHIFT;
          end else begin
            lanes_nxt = {{uad_pkg::PAD_W{1'b0}}, item.value[uad_pkg::CONV_WIDTH-1:0]};
            done_nxt  = 1'b1;
          end
        end
      end
      C_SHIFT: begin
        lanes_nxt = {adj_bits[uad_pkg::LANE_BITS-2:0], bits_r[uad_pkg::CONV_WIDTH-1]};
        bits_nxt  = {bits_r[uad_pkg::CONV_WIDTH-2:0], 1'b0};
        cnt_nxt   = cnt_r - 1'b1;
        if (cnt_r == uad_pkg::BIT_CNT_W'(1)) begin
          done_nxt  = 1'b1;
          state_nxt = C_IDLE;
        end
      end
      default: begin
        state_nxt = C_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    upper_r <= upper_nxt;
    lanes_r <= lanes_nxt;
    bits_r  <= bits_nxt;
    cnt_r   <= cnt_nxt;
  end

  assign busy         = (state_r == C_SHIFT) || done_r;
  assign result.valid = done_r;
  assign result.upper = upper_r;
  assign result.lanes = lanes_r;

endmodule

// ----- rtl/uad_emit.sv -----
// ----------------------------------------------------------------------------
// uad_emit
// Digit emitter: drops leading zero digits one per cycle, then shifts the
// remaining digits out most significant first through an output register.
// ----------------------------------------------------------------------------
module uad_emit (
  input  logic                  clk,
  input  logic                  rst_n,
  input  uad_pkg::conv_result_t conv,
  output logic                  busy,
  output logic                  out_valid,
  input  logic                  out_stall,
  output uad_pkg::out_item_t    out_item
);

  typedef enum logic [2:0] {
    E_IDLE = 3'b001,
    E_SKIP = 3'b010,
    E_EMIT = 3'b100
  } emit_state_t;

  emit_state_t                  state_r, state_nxt;
  uad_pkg::lanes_t              lanes_r, lanes_nxt;
  logic                         upper_r, upper_nxt;
  logic [uad_pkg::REM_W-1:0]    rem_r, rem_nxt;
  logic [uad_pkg::REM_W-1:0]    len_r, len_nxt;
  logic                         out_valid_r, out_valid_nxt;
  uad_pkg::out_item_t           out_r, out_nxt;
  logic [3:0]                   top;
  logic                         last;
  logic                         load;

  assign top  = lanes_r[uad_pkg::LANES-1];
  assign last = (rem_r == uad_pkg::REM_W'(1));
  assign load = (state_r == E_EMIT) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt     = state_r;
    lanes_nxt     = lanes_r;
    upper_nxt     = upper_r;
    rem_nxt       = rem_r;
    len_nxt       = len_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      E_IDLE: begin
        if (conv.valid) begin
          lanes_nxt = conv.lanes;
          upper_nxt = conv.upper;
          rem_nxt   = uad_pkg::REM_W'(uad_pkg::LANES);
          state_nxt = E_SKIP;
        end
      end
      E_SKIP: begin
        if (top == 4'd0 && !last) begin
          lanes_nxt = {lanes_r[uad_pkg::LANES-2:0], 4'd0};
          rem_nxt   = rem_r - 1'b1;
        end else begin
          len_nxt   = rem_r;
          state_nxt = E_EMIT;
        end
      end
      E_EMIT: begin
        if (load) begin
          out_nxt.ascii_char = uad_pkg::digit_char(top, upper_r);
          out_nxt.last_char  = last;
          out_nxt.char_count = last ? uad_pkg::CNT_W'(len_r) : '0;
          out_valid_nxt      = 1'b1;
          lanes_nxt          = {lanes_r[uad_pkg::LANES-2:0], 4'd0};
          rem_nxt            = rem_r - 1'b1;
          if (last) begin
            state_nxt = E_IDLE;
          end
        end
      end
      default: begin
        state_nxt = E_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= E_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    lanes_r <= lanes_nxt;
    upper_r <= upper_nxt;
    rem_r   <= rem_nxt;
    len_r   <= len_nxt;
    out_r   <= out_nxt;
  end

  assign busy      = (state_r != E_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

// ----- rtl/unsigned_to_ascii_digits.sv -----
// ----------------------------------------------------------------------------
// unsigned_to_ascii_digits
// Converts an unsigned value to ASCII decimal or hex digits, MSB first.
// ----------------------------------------------------------------------------
// One number is in flight at a time; in_stall stays high from the accepted
// transfer until the last character has been loaded into the output register.
// A decimal request passes through the accepting cycle, the bit-serial
// shift-add-3 conversion, a handoff into the emitter, the dropping of leading
// zeros and emitting of characters (always 10 together) and a switch from
// dropping to emitting before the next request can be accepted. A hex request
// skips the conversion. While the output register is full and stalled, the
// request is held up. Characters leave at one per cycle while out_stall is
// low; last_char marks the final one, which also carries char_count. Request
// type 3 behaves as upper-case hex.
module unsigned_to_ascii_digits (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  uad_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output uad_pkg::out_item_t out_item
);

  logic                  accept;
  logic                  conv_busy;
  logic                  emit_busy;
  uad_pkg::conv_result_t conv;

  assign in_stall = conv_busy || emit_busy;
  assign accept   = in_valid && !in_stall;

  uad_conv u_conv (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (accept),
    .item   (in_item),
    .busy   (conv_busy),
    .result (conv)
  );

  uad_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .conv      (conv),
    .busy      (emit_busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

// ----- tb/sv/digit_checker.sv -----
// ----------------------------------------------------------------------------
// digit_checker
// Watches both channels of the ASCII digit converter. For every input transfer
// it computes the expected digit string (decimal, lower- or upper-case hex,
// no leading zeros) and queues one expected character per digit. Each output
// transfer is compared field by field with the oldest queued character.
// ----------------------------------------------------------------------------
module digit_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  uad_pkg::in_item_t  in_item,
  input  logic               out_valid,
  input  logic               out_stall,
  input  uad_pkg::out_item_t out_item,
  output int                 fail_count,
  output int                 chars_pending,
  output int                 chars_checked,
  output int                 numbers_checked
);

  localparam logic [6:0] ASCII_0 = 7'h30;
  localparam logic [6:0] ASCII_LC_A = 7'h61;
  localparam logic [6:0] ASCII_UC_A = 7'h41;

  uad_pkg::out_item_t expected_chars[$];
  uad_pkg::out_item_t want;

  initial begin
    fail_count = 0;
    chars_pending = 0;
    chars_checked = 0;
    numbers_checked = 0;
  end

  task automatic report_mismatch(input string msg);
    fail_count++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // Digits are produced least significant first, then queued in print order.
  function automatic void queue_digits(input uad_pkg::in_item_t it);
    logic [31:0]        rest;
    logic [3:0]         nib;
    logic [6:0]         digs [10];
    int                 n;
    uad_pkg::out_item_t c;
    rest = it.value;
    n = 0;
    if (it.req_type == uad_pkg::REQ_DEC) begin
      do begin
        digs[n] = ASCII_0 + 7'(rest % 32'd10);
        rest = rest / 32'd10;
        n++;
      end while (rest != 0);
    end else begin
      // unused code 3 falls through to upper case
      do begin
        nib = rest[3:0];
        if (nib < 4'd10) begin
          digs[n] = ASCII_0 + 7'(nib);
        end else if (it.req_type == uad_pkg::REQ_HEX_LOWER) begin
          digs[n] = ASCII_LC_A + 7'(nib - 4'd10);
        end else begin
          digs[n] = ASCII_UC_A + 7'(nib - 4'd10);
        end
        rest = rest >> 4;
        n++;
      end while (rest != 0);
    end
    for (int k = n - 1; k >= 0; k--) begin
      c.ascii_char = digs[k];
      c.last_char  = (k == 0);
      c.char_count = (k == 0) ? 4'(n) : 4'd0;
      expected_chars.push_back(c);
    end
  endfunction

  // Compare before predicting: a new number never yields a char on its own
  // accepting edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_chars.size() == 0) begin
          report_mismatch($sformatf("unexpected char 0x%02h", out_item.ascii_char));
        end else begin
          want = expected_chars.pop_front();
          if (out_item.ascii_char !== want.ascii_char)
            report_mismatch($sformatf("ascii_char got 0x%02h want 0x%02h",
                                      out_item.ascii_char, want.ascii_char));
          if (out_item.last_char !== want.last_char)
            report_mismatch($sformatf("last_char got %0b want %0b",
                                      out_item.last_char, want.last_char));
          if (out_item.char_count !== want.char_count)
            report_mismatch($sformatf("char_count got %0d want %0d",
                                      out_item.char_count, want.char_count));
          chars_checked++;
          if (want.last_char) numbers_checked++;
        end
      end
      if (in_valid && !in_stall) queue_digits(in_item);
    end
    chars_pending = expected_chars.size();
  end

endmodule

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Drives the ASCII digit converter with directed corner values (zero, all
// ones, powers of ten, every conversion type including the spare code) and
// then random values of spread-out magnitude, with random gaps on the input,
// random output stalls and long output hold-offs that back up the input.
// ----------------------------------------------------------------------------
module tb_top;

  localparam logic [1:0] REQ_SPARE = 2'd3;
  localparam int RANDOM_ITEMS = 306;
  localparam int BLOCK_ITEMS = 40;
  localparam int HOLD_CYCLES = 80;
  localparam int TAIL_CYCLES = 60;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  uad_pkg::in_item_t  in_item;
  logic               out_valid;
  logic               out_stall;
  uad_pkg::out_item_t out_item;

  int fail_count;
  int chars_pending;
  int chars_checked;
  int numbers_checked;
  int type_tally [4];
  bit tx_idle;
  bit rx_idle;
  bit hold_req;

  unsigned_to_ascii_digits dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  digit_checker chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_item        (in_item),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_item       (out_item),
    .fail_count     (fail_count),
    .chars_pending  (chars_pending),
    .chars_checked  (chars_checked),
    .numbers_checked(numbers_checked)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("timeout with %0d chars still expected", chars_pending);
    $display("== FAIL ==");
    $finish;
  end

  task automatic send_item(input logic [1:0] req, input logic [31:0] value);
    int gap;
    gap = tx_idle ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= '{req_type: req, value: value};
    type_tally[req]++;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic logic [31:0] random_value();
    logic [31:0] p;
    p = 32'd1;
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return 32'($urandom_range(0, 15));
      3: begin
        repeat ($urandom_range(0, 9)) p = p * 32'd10;
        return p + 32'($urandom_range(0, 2)) - 32'd1;
      end
      default: return $urandom >> $urandom_range(0, 31);
    endcase
  endfunction

  // receiver: per-char stall draw, plus long hold-offs on request
  initial begin
    int n;
    out_stall = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        n = 0;
        while (n < HOLD_CYCLES) begin
          @(posedge clk);
          n++;
        end
        hold_req = 1'b0;
      end
      n = rx_idle ? $urandom_range(0, 7) : 0;
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin
    in_valid = 1'b0;
    in_item  = '0;
    rst_n    = 1'b0;
    tx_idle  = 1'b1;
    rx_idle  = 1'b1;
    hold_req = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(uad_pkg::REQ_DEC, 32'd0);
    send_item(uad_pkg::REQ_HEX_LOWER, 32'd0);
    send_item(uad_pkg::REQ_HEX_UPPER, 32'd0);
    send_item(REQ_SPARE, 32'd0);
    send_item(uad_pkg::REQ_DEC, 32'hFFFF_FFFF);
    send_item(uad_pkg::REQ_HEX_LOWER, 32'hFFFF_FFFF);
    send_item(uad_pkg::REQ_HEX_UPPER, 32'hFFFF_FFFF);
    send_item(REQ_SPARE, 32'hFFFF_FFFF);
    send_item(uad_pkg::REQ_DEC, 32'd9);
    send_item(uad_pkg::REQ_DEC, 32'd10);
    send_item(uad_pkg::REQ_DEC, 32'd999_999_999);
    send_item(uad_pkg::REQ_DEC, 32'd1_000_000_000);
    send_item(uad_pkg::REQ_DEC, 32'd2_147_483_648);
    send_item(uad_pkg::REQ_DEC, 32'd4_294_967_294);
    send_item(uad_pkg::REQ_DEC, 32'd1_234_567_890);
    send_item(uad_pkg::REQ_HEX_LOWER, 32'h0000_000A);
    send_item(uad_pkg::REQ_HEX_UPPER, 32'h0000_000F);
    send_item(uad_pkg::REQ_HEX_LOWER, 32'h0000_0010);
    send_item(uad_pkg::REQ_HEX_LOWER, 32'hABCD_EF01);
    send_item(uad_pkg::REQ_HEX_UPPER, 32'hABCD_EF01);
    send_item(REQ_SPARE, 32'h89AB_CDEF);
    send_item(uad_pkg::REQ_HEX_UPPER, 32'h8000_0000);
    send_item(uad_pkg::REQ_HEX_LOWER, 32'h0000_0001);
    send_item(uad_pkg::REQ_DEC, 32'h5555_5555);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % BLOCK_ITEMS == 0) begin
        tx_idle = $urandom_range(0, 1);
        rx_idle = $urandom_range(0, 1);
      end
      if (i == 60 || i == 210) hold_req = 1'b1;
      send_item(2'($urandom_range(0, 3)), random_value());
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (chars_pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("converted %0d numbers, %0d chars checked", numbers_checked, chars_checked);
    $display("requests: dec %0d, hex lower %0d, hex upper %0d, spare code %0d",
             type_tally[uad_pkg::REQ_DEC], type_tally[uad_pkg::REQ_HEX_LOWER],
             type_tally[uad_pkg::REQ_HEX_UPPER], type_tally[REQ_SPARE]);
    if (fail_count == 0 && chars_pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
